// ----- src/kwc_pkg.sv -----
// kwc_pkg: shared constants, keyword rom, compare and state types of the keyword counter
// depends on nothing; used by the core, kwc_cmp and kwc_search
`default_nettype none

package kwc_pkg;

	// default parameter values
	localparam int NUM_KEYWORDS_DEF = 11;
	localparam int MAX_WORD_DEF     = 100;
	localparam int MAX_KEY_LEN_DEF  = 8;

	// keyword rom geometry
	localparam int ROM_SIZE  = 11;
	localparam int ROM_WIDTH = 8;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 16;
	localparam int CMP_W     = 9;

	// sorted keyword table, first character at index 0
	localparam logic [7:0] KW_ROM [ROM_SIZE][ROM_WIDTH] = '{
		'{"a", "u", "t", "o", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
		'{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
		'{"c", "o", "n", "t", "i", "n", "u", "e"},
		'{"d", "e", "f", "a", "u", "l", "t", 8'h00},
		'{"u", "n", "s", "i", "g", "n", "e", "d"},
		'{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"v", "o", "l", "a", "t", "i", "l", "e"},
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] KW_LEN [ROM_SIZE] = '{
		4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd8, 4'd4, 4'd8, 4'd5
	};

	// outcome of one probe of the compare unit
	typedef enum logic [1:0] {
		CMP_LT,
		CMP_EQ,
		CMP_GT
	} kwc_cmp_t;

	// search sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE
	} kwc_state_t;

	// word handoff from the assembler to the search unit
	typedef struct packed {
		logic start;
		logic too_long;
	} kwc_req_t;

	// search unit status and result
	typedef struct packed {
		logic             idle;
		logic             valid;
		logic             is_keyword;
		logic [IDX_W-1:0] keyword_index;
		logic [CNT_W-1:0] keyword_count;
	} kwc_rsp_t;

endpackage

`default_nettype wire

// ----- src/kwc_if.sv -----
// kwc_in_if / kwc_out_if: valid-ready channels for characters and keyword results
// depends on nothing
`default_nettype none

interface kwc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;

	modport source (output valid, ch, end_of_input, input ready);
	modport sink (input valid, ch, end_of_input, output ready);
endinterface

interface kwc_out_if;
	logic        valid;
	logic        ready;
	logic        is_keyword;
	logic [3:0]  keyword_index;
	logic [15:0] keyword_count;

	modport source (output valid, is_keyword, keyword_index, keyword_count, input ready);
	modport sink (input valid, is_keyword, keyword_index, keyword_count, output ready);
endinterface

`default_nettype wire

// ----- src/keyword_word_counter_core.sv -----
// Keyword word counter: one character per transaction; a finished word is binary searched in
// an 11-entry keyword rom, one probe per cycle through a shared compare unit.
// A character that does not end a word leaves ready high; the transaction that ends a word
// starts a search of up to 4 probes, then a counter update that puts its result in the output
// register once that is free, and ready stays low meanwhile. Words over the key length skip the
// search. Asynchronous reset clears word state and all hit counters at once.
// depends on kwc_pkg, kwc_if, kwc_search
`default_nettype none

module keyword_word_counter_core #(
	parameter int NUM_KEYWORDS = kwc_pkg::NUM_KEYWORDS_DEF,
	parameter int MAX_WORD     = kwc_pkg::MAX_WORD_DEF,
	parameter int MAX_KEY_LEN  = kwc_pkg::MAX_KEY_LEN_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	kwc_in_if.sink   chars,
	kwc_out_if.source results
);

	localparam int LEN_W = $clog2(MAX_WORD);
	localparam int CW    = kwc_pkg::CMP_W;

	logic [MAX_KEY_LEN-1:0][7:0] word_chars_q;
	logic [LEN_W-1:0]            word_length_q, len_n;
	logic                        in_word_q, in_word_n;
	logic                        store_en;
	logic [LEN_W-1:0]            store_pos;
	logic                        in_fire;
	logic                        is_letter;
	logic                        is_alnum;
	kwc_pkg::kwc_req_t           req;
	kwc_pkg::kwc_rsp_t           rsp;
	logic                        out_free;
	logic                        out_valid_q;
	logic                        is_keyword_q;
	logic [kwc_pkg::IDX_W-1:0]   keyword_index_q;
	logic [kwc_pkg::CNT_W-1:0]   keyword_count_q;

	assign chars.ready = rsp.idle;
	assign in_fire     = chars.valid && chars.ready;

	// character classes
	assign is_letter = (chars.ch >= "A" && chars.ch <= "Z") ||
		(chars.ch >= "a" && chars.ch <= "z");
	assign is_alnum  = is_letter || (chars.ch >= "0" && chars.ch <= "9");

	// word assembly and word completion
	always_comb begin
		len_n        = word_length_q;
		in_word_n    = in_word_q;
		store_en     = 1'b0;
		store_pos    = word_length_q;
		req.start    = 1'b0;
		if (in_fire) begin
			priority if (chars.end_of_input) begin
				if (in_word_q) begin
					req.start = 1'b1;
					in_word_n = 1'b0;
				end
			end else if (in_word_q) begin
				if (!is_alnum) begin
					req.start = 1'b1;
					in_word_n = 1'b0;
				end else begin
					store_en = 1'b1;
					len_n    = word_length_q + LEN_W'(1);
					if (len_n >= LEN_W'(MAX_WORD - 1)) begin
						req.start = 1'b1;
						in_word_n = 1'b0;
					end
				end
			end else if (is_letter) begin
				in_word_n = 1'b1;
				store_en  = 1'b1;
				store_pos = LEN_W'(0);
				len_n     = LEN_W'(1);
				if (len_n >= LEN_W'(MAX_WORD - 1)) begin
					req.start = 1'b1;
					in_word_n = 1'b0;
				end
			end
		end
		req.too_long = CW'(len_n) > CW'(MAX_KEY_LEN);
	end

	// word length and in-word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_length_q <= '0;
			in_word_q     <= 1'b0;
		end else begin
			word_length_q <= len_n;
			in_word_q     <= in_word_n;
		end
	end

	// first characters of the word
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_KEY_LEN; i++) begin
			if (store_en && CW'(store_pos) == CW'(i)) begin
				word_chars_q[i] <= chars.ch;
			end
		end
	end

	kwc_search #(
		.NUM_KEYWORDS (NUM_KEYWORDS),
		.MAX_WORD     (MAX_WORD),
		.MAX_KEY_LEN  (MAX_KEY_LEN)
	) u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.word_chars   (word_chars_q),
		.word_length  (word_length_q),
		.res_ready    (out_free),
		.rsp          (rsp)
	);

	// output register
	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= rsp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && rsp.valid) begin
			is_keyword_q    <= rsp.is_keyword;
			keyword_index_q <= rsp.keyword_index;
			keyword_count_q <= rsp.keyword_count;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.is_keyword    = is_keyword_q;
	assign results.keyword_index = keyword_index_q;
	assign results.keyword_count = keyword_count_q;

endmodule

`default_nettype wire

// ----- src/kwc_cmp.sv -----
// kwc_cmp: byte-order compare of the stored word against one keyword rom entry
// depends on kwc_pkg
`default_nettype none

module kwc_cmp #(
	parameter int MAX_WORD    = kwc_pkg::MAX_WORD_DEF,
	parameter int MAX_KEY_LEN = kwc_pkg::MAX_KEY_LEN_DEF,
	localparam int LEN_W      = $clog2(MAX_WORD),
	localparam int NCMP       = (MAX_KEY_LEN < kwc_pkg::ROM_WIDTH) ?
		MAX_KEY_LEN : kwc_pkg::ROM_WIDTH
) (
	input  wire logic [MAX_KEY_LEN-1:0][7:0]    word_chars,
	input  wire logic [LEN_W-1:0]               word_length,
	input  wire logic [kwc_pkg::IDX_W-1:0]      key_sel,
	output      kwc_pkg::kwc_cmp_t              result
);

	logic [kwc_pkg::CMP_W-1:0] wlen;
	logic [kwc_pkg::CMP_W-1:0] klen;
	logic                      diff_found;
	logic                      diff_lt;
	logic [7:0]                key_ch;

	// lowest differing position inside the common length decides
	always_comb begin
		wlen       = kwc_pkg::CMP_W'(word_length);
		klen       = kwc_pkg::CMP_W'(kwc_pkg::KW_LEN[key_sel]);
		diff_found = 1'b0;
		diff_lt    = 1'b0;
		key_ch     = 8'h00;
		for (int i = NCMP - 1; i >= 0; i--) begin
			key_ch = kwc_pkg::KW_ROM[key_sel][i];
			if (kwc_pkg::CMP_W'(i) < wlen && kwc_pkg::CMP_W'(i) < klen &&
					word_chars[i] != key_ch) begin
				diff_found = 1'b1;
				diff_lt    = word_chars[i] < key_ch;
			end
		end
	end

	// equal prefix falls back to the length order
	always_comb begin
		priority if (diff_found) begin
			result = diff_lt ? kwc_pkg::CMP_LT : kwc_pkg::CMP_GT;
		end else if (wlen == klen) begin
			result = kwc_pkg::CMP_EQ;
		end else if (wlen < klen) begin
			result = kwc_pkg::CMP_LT;
		end else begin
			result = kwc_pkg::CMP_GT;
		end
	end

endmodule

`default_nettype wire

// ----- src/kwc_search.sv -----
// kwc_search: binary search sequencer over the keyword rom and the saturating hit counters
// depends on kwc_pkg and kwc_cmp
`default_nettype none

module kwc_search #(
	parameter int NUM_KEYWORDS = kwc_pkg::NUM_KEYWORDS_DEF,
	parameter int MAX_WORD     = kwc_pkg::MAX_WORD_DEF,
	parameter int MAX_KEY_LEN  = kwc_pkg::MAX_KEY_LEN_DEF,
	localparam int LEN_W       = $clog2(MAX_WORD),
	localparam int TBL         = (NUM_KEYWORDS < kwc_pkg::ROM_SIZE) ?
		NUM_KEYWORDS : kwc_pkg::ROM_SIZE
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire kwc_pkg::kwc_req_t            req,
	input  wire logic [MAX_KEY_LEN-1:0][7:0]  word_chars,
	input  wire logic [LEN_W-1:0]             word_length,
	input  wire logic                         res_ready,
	output      kwc_pkg::kwc_rsp_t            rsp
);

	localparam int IW = kwc_pkg::IDX_W;
	localparam int CW = kwc_pkg::CNT_W;

	kwc_pkg::kwc_state_t state_q, state_n;
	logic [IW-1:0]       lo_q, lo_n;
	logic [IW-1:0]       hi_q, hi_n;
	logic                found_q, found_n;
	logic [IW-1:0]       idx_q, idx_n;
	logic [CW-1:0]       counts_q [kwc_pkg::ROM_SIZE];
	logic [IW:0]         mid_sum;
	logic [IW-1:0]       mid;
	logic [IW-1:0]       mid_inc;
	kwc_pkg::kwc_cmp_t   cmp_res;
	logic [CW-1:0]       cnt_cur;
	logic [CW-1:0]       cnt_inc;
	logic                bump;

	// probe midpoint of the half-open range [lo, hi)
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (IW+1)'(1);
	assign mid     = mid_sum[IW:1];
	assign mid_inc = mid + IW'(1);

	// shared compare unit
	kwc_cmp #(
		.MAX_WORD    (MAX_WORD),
		.MAX_KEY_LEN (MAX_KEY_LEN)
	) u_cmp (
		.word_chars  (word_chars),
		.word_length (word_length),
		.key_sel     (mid),
		.result      (cmp_res)
	);

	// saturating increment of the hit counter
	assign cnt_cur = counts_q[idx_q];
	assign cnt_inc = (cnt_cur == {CW{1'b1}}) ? cnt_cur : cnt_cur + CW'(1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kwc_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state, search bounds and result
	always_comb begin
		state_n           = state_q;
		lo_n              = lo_q;
		hi_n              = hi_q;
		found_n           = found_q;
		idx_n             = idx_q;
		bump              = 1'b0;
		rsp.idle          = 1'b0;
		rsp.valid         = 1'b0;
		rsp.is_keyword    = found_q;
		rsp.keyword_index = found_q ? idx_q : IW'(0);
		rsp.keyword_count = found_q ? cnt_inc : CW'(0);
		unique case (state_q)
			kwc_pkg::ST_IDLE: begin
				rsp.idle = 1'b1;
				lo_n     = IW'(0);
				hi_n     = IW'(TBL);
				found_n  = 1'b0;
				idx_n    = IW'(0);
				if (req.start) begin
					state_n = req.too_long ? kwc_pkg::ST_UPDATE : kwc_pkg::ST_SEARCH;
				end
			end
			kwc_pkg::ST_SEARCH: begin
				priority if (cmp_res == kwc_pkg::CMP_EQ) begin
					found_n = 1'b1;
					idx_n   = mid;
					state_n = kwc_pkg::ST_UPDATE;
				end else if (cmp_res == kwc_pkg::CMP_LT) begin
					hi_n = mid;
					if (lo_q >= mid) begin
						state_n = kwc_pkg::ST_UPDATE;
					end
				end else begin
					lo_n = mid_inc;
					if (mid_inc >= hi_q) begin
						state_n = kwc_pkg::ST_UPDATE;
					end
				end
			end
			kwc_pkg::ST_UPDATE: begin
				rsp.valid = 1'b1;
				if (res_ready) begin
					bump    = found_q;
					state_n = kwc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = kwc_pkg::ST_IDLE;
			end
		endcase
	end

	// search bounds and match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q    <= '0;
			hi_q    <= '0;
			found_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			lo_q    <= lo_n;
			hi_q    <= hi_n;
			found_q <= found_n;
			idx_q   <= idx_n;
		end
	end

	// hit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kwc_pkg::ROM_SIZE; i++) begin
				counts_q[i] <= '0;
			end
		end else if (bump) begin
			counts_q[idx_q] <= cnt_inc;
		end
	end

`ifndef SYNTHESIS
	// a probe always has a non-empty range inside the table
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kwc_pkg::ST_SEARCH |-> lo_q < hi_q && hi_q <= IW'(TBL))
		else $error("search range empty or past table");

	// a match points into the searched part of the table
	a_found_idx: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> idx_q < IW'(TBL))
		else $error("match index outside table");

	// a delivered result returns the sequencer to idle
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && res_ready |=> state_q == kwc_pkg::ST_IDLE)
		else $error("sequencer did not return to idle");

	// a reported count is never zero for a match
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && found_q |-> rsp.keyword_count != CW'(0))
		else $error("keyword match with zero count");
`endif

endmodule

`default_nettype wire
